// ===== rtl/bpa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the buddy page allocator.
// No dependencies; bpa_seq and buddy_page_allocator import this package.
package bpa_pkg;

   // Fixed widths of the channel fields.
   localparam int PAGE_FIELD_W = 10;
   localparam int ORD_FIELD_W  = 4;

   // Default pool geometry.
   localparam int DEF_MAX_ORDER  = 10;
   localparam int DEF_POOL_PAGES = 1024;

   // Request operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOM = 1'b1;

   typedef struct packed {
      logic                    op;
      logic [ORD_FIELD_W-1:0]  req_order;
      logic [PAGE_FIELD_W-1:0] free_page;
   } req_type;

   typedef struct packed {
      logic                    status;
      logic [PAGE_FIELD_W-1:0] block_page;
      logic [ORD_FIELD_W-1:0]  block_order;
   } rsp_type;

endpackage

// ===== rtl/bpa_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one read port with registered data.
// No dependencies.
module bpa_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bpa_seq.sv =====
`timescale 1ns / 1ps
// Sequencer of the buddy allocator: free-list heads, link and page memories, and the
// step-by-step alloc/split and free/coalesce walks. Depends on bpa_pkg and bpa_ram.
module bpa_seq #(
   parameter int MAX_ORDER  = bpa_pkg::DEF_MAX_ORDER,
   parameter int POOL_PAGES = bpa_pkg::DEF_POOL_PAGES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bpa_pkg::req_type req_data,
   output logic             done_valid,
   input  logic             done_ready,
   output bpa_pkg::rsp_type done_data
);
   import bpa_pkg::*;

   localparam int AW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int LW = AW + 1;
   localparam int IW = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
   localparam int BW = ((AW > MAX_ORDER) ? AW : MAX_ORDER) + 1;
   localparam int MW = IW + 1;
   localparam logic [LW-1:0] NIL = LW'(POOL_PAGES);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_ASCAN = 4'd2;
   localparam logic [3:0] ST_ULRD  = 4'd3;
   localparam logic [3:0] ST_ULWR  = 4'd4;
   localparam logic [3:0] ST_SPLIT = 4'd5;
   localparam logic [3:0] ST_PUSH1 = 4'd6;
   localparam logic [3:0] ST_PUSH2 = 4'd7;
   localparam logic [3:0] ST_AFIN  = 4'd8;
   localparam logic [3:0] ST_FMETA = 4'd9;
   localparam logic [3:0] ST_FORD  = 4'd10;
   localparam logic [3:0] ST_FCHK  = 4'd11;
   localparam logic [3:0] ST_FBUD  = 4'd12;
   localparam logic [3:0] ST_DONE  = 4'd13;

   logic [3:0]              state_ff, state_in;
   logic                    op_ff, op_in;
   logic [ORD_FIELD_W-1:0]  req_ff, req_in;
   logic [PAGE_FIELD_W-1:0] fp_ff, fp_in;
   logic [IW-1:0]           k_ff, k_in;
   logic [AW-1:0]           b_ff, b_in;
   logic [AW-1:0]           x_ff, x_in;
   logic [LW-1:0]           h_ff, h_in;
   logic [AW-1:0]           clr_ff, clr_in;
   rsp_type                 res_ff, res_in;
   logic [LW-1:0]           head_ff [MAX_ORDER+1];
   logic [LW-1:0]           head_in [MAX_ORDER+1];

   // Memory ports.
   logic          nx_we, pv_we, mt_we;
   logic [AW-1:0] nx_wa, pv_wa, mt_wa;
   logic [LW-1:0] nx_wd, pv_wd;
   logic [MW-1:0] mt_wd;
   logic [AW-1:0] lk_ra, mt_ra;
   logic [LW-1:0] nx_rd, pv_rd;
   logic [MW-1:0] mt_rd;

   // Scratch values of the walk.
   logic [LW-1:0] head_k;
   logic [BW-1:0] bud_w;
   logic [BW-1:0] split_w;
   logic [IW-1:0] k_dec;
   logic [IW-1:0] rd_ord;

   bpa_ram #(.DEPTH(POOL_PAGES), .ADDR_W(AW), .DATA_W(LW)) u_next (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_addr(lk_ra), .rd_data(nx_rd)
   );

   bpa_ram #(.DEPTH(POOL_PAGES), .ADDR_W(AW), .DATA_W(LW)) u_prev (
      .clock(clock), .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
      .rd_addr(lk_ra), .rd_data(pv_rd)
   );

   // Page metadata entry: free flag over block order.
   bpa_ram #(.DEPTH(POOL_PAGES), .ADDR_W(AW), .DATA_W(MW)) u_meta (
      .clock(clock), .wr_en(mt_we), .wr_addr(mt_wa), .wr_data(mt_wd),
      .rd_addr(mt_ra), .rd_data(mt_rd)
   );

   assign head_k  = head_ff[k_ff];
   assign bud_w   = BW'(b_ff) ^ (BW'(1) << k_ff);
   assign k_dec   = k_ff - IW'(1);
   assign split_w = BW'(b_ff) ^ (BW'(1) << k_dec);
   assign rd_ord  = (32'(mt_rd[IW-1:0]) > MAX_ORDER) ? IW'(MAX_ORDER) : mt_rd[IW-1:0];

   // Next-state logic of the walk.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      req_in   = req_ff;
      fp_in    = fp_ff;
      k_in     = k_ff;
      b_in     = b_ff;
      x_in     = x_ff;
      h_in     = h_ff;
      clr_in   = clr_ff;
      res_in   = res_ff;
      head_in  = head_ff;
      nx_we = 1'b0; nx_wa = x_ff; nx_wd = NIL;
      pv_we = 1'b0; pv_wa = x_ff; pv_wd = NIL;
      mt_we = 1'b0; mt_wa = x_ff; mt_wd = '0;
      lk_ra = x_ff;
      mt_ra = x_ff;
      req_ready  = 1'b0;
      done_valid = 1'b0;

      unique case (state_ff)
         // Sweep the page memories once after reset.
         ST_CLEAR: begin
            mt_we = 1'b1; mt_wa = clr_ff;
            nx_we = 1'b1; nx_wa = clr_ff;
            pv_we = 1'b1; pv_wa = clr_ff;
            mt_wd = (clr_ff == '0) ? {1'b1, IW'(MAX_ORDER)} : '0;
            clr_in = clr_ff + AW'(1);
            if (32'(clr_ff) == POOL_PAGES - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in  = req_data.op;
               req_in = req_data.req_order;
               fp_in  = req_data.free_page;
               k_in   = IW'(req_data.req_order);
               state_in = (req_data.op == OP_FREE) ? ST_FMETA : ST_ASCAN;
            end
         end
         // Look for the smallest non-empty list at or above the request.
         ST_ASCAN: begin
            if (32'(req_ff) > MAX_ORDER) begin
               res_in = '{status: STATUS_OOM, block_page: '0, block_order: '0};
               state_in = ST_DONE;
            end else if (head_k < NIL) begin
               b_in = AW'(head_k);
               x_in = AW'(head_k);
               state_in = ST_ULRD;
            end else if (32'(k_ff) == MAX_ORDER) begin
               res_in = '{status: STATUS_OOM, block_page: '0, block_order: '0};
               state_in = ST_DONE;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         // Unlink page x_ff from list k_ff: fetch its links, then patch neighbors.
         ST_ULRD: begin
            lk_ra = x_ff;
            state_in = ST_ULWR;
         end
         ST_ULWR: begin
            if (pv_rd < NIL) begin
               nx_we = 1'b1; nx_wa = AW'(pv_rd); nx_wd = nx_rd;
            end else begin
               head_in[k_ff] = nx_rd;
            end
            if (nx_rd < NIL) begin
               pv_we = 1'b1; pv_wa = AW'(nx_rd); pv_wd = pv_rd;
            end
            mt_we = 1'b1; mt_wa = x_ff; mt_wd = {1'b0, k_ff};
            if (op_ff == OP_ALLOC) begin
               state_in = ST_SPLIT;
            end else begin
               b_in = (x_ff < b_ff) ? x_ff : b_ff;
               k_in = k_ff + IW'(1);
               state_in = ST_FCHK;
            end
         end
         // Split one order down and hand the upper buddy to the push steps.
         ST_SPLIT: begin
            if (k_ff > IW'(req_ff)) begin
               k_in = k_dec;
               x_in = AW'(split_w);
               if (split_w < BW'(POOL_PAGES)) begin
                  state_in = ST_PUSH1;
               end
            end else begin
               state_in = ST_AFIN;
            end
         end
         // Push x_ff at the head of list k_ff.
         ST_PUSH1: begin
            nx_we = 1'b1; nx_wa = x_ff; nx_wd = head_k;
            pv_we = 1'b1; pv_wa = x_ff; pv_wd = NIL;
            mt_we = 1'b1; mt_wa = x_ff; mt_wd = {1'b1, k_ff};
            h_in = head_k;
            head_in[k_ff] = LW'(x_ff);
            state_in = ST_PUSH2;
         end
         ST_PUSH2: begin
            if (h_ff < NIL) begin
               pv_we = 1'b1; pv_wa = AW'(h_ff); pv_wd = LW'(x_ff);
            end
            if (op_ff == OP_ALLOC) begin
               state_in = ST_SPLIT;
            end else begin
               res_in = '{status: STATUS_OK, block_page: PAGE_FIELD_W'(b_ff),
                          block_order: ORD_FIELD_W'(k_ff)};
               state_in = ST_DONE;
            end
         end
         ST_AFIN: begin
            mt_we = 1'b1; mt_wa = b_ff; mt_wd = {1'b0, IW'(req_ff)};
            res_in = '{status: STATUS_OK, block_page: PAGE_FIELD_W'(b_ff),
                       block_order: req_ff};
            state_in = ST_DONE;
         end
         // Free: fetch the order of the block, then coalesce upward.
         ST_FMETA: begin
            if (32'(fp_ff) >= POOL_PAGES) begin
               res_in = '{status: STATUS_OK, block_page: fp_ff, block_order: '0};
               state_in = ST_DONE;
            end else begin
               mt_ra = AW'(fp_ff);
               b_in  = AW'(fp_ff);
               state_in = ST_FORD;
            end
         end
         ST_FORD: begin
            k_in = rd_ord;
            state_in = ST_FCHK;
         end
         ST_FCHK: begin
            if (32'(k_ff) < MAX_ORDER && bud_w < BW'(POOL_PAGES)) begin
               mt_ra = AW'(bud_w);
               x_in  = AW'(bud_w);
               state_in = ST_FBUD;
            end else begin
               x_in = b_ff;
               state_in = ST_PUSH1;
            end
         end
         ST_FBUD: begin
            if (mt_rd[MW-1] && mt_rd[IW-1:0] == k_ff) begin
               state_in = ST_ULRD;
            end else begin
               x_in = b_ff;
               state_in = ST_PUSH1;
            end
         end
         ST_DONE: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         for (int i = 0; i <= MAX_ORDER; i++) begin
            head_ff[i] <= (i == MAX_ORDER) ? LW'(0) : NIL;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         head_ff  <= head_in;
      end
   end

   // Working registers of the current beat.
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      req_ff <= req_in;
      fp_ff  <= fp_in;
      k_ff   <= k_in;
      b_ff   <= b_in;
      x_ff   <= x_in;
      h_ff   <= h_in;
      res_ff <= res_in;
   end

   assign done_data = res_ff;

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during the clearing sweep");

   // The order counter still holds the raw request field until the walk proper starts.
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_CLEAR && state_ff != ST_ASCAN &&
       state_ff != ST_FMETA && state_ff != ST_FORD && state_ff != ST_DONE)
      |-> (32'(k_ff) <= MAX_ORDER))
      else $error("order counter beyond the largest order");

   a_done_return: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && done_ready) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after its result");

   a_alloc_order: assert property (@(posedge clock) disable iff (reset)
      (done_valid && op_ff == OP_ALLOC && res_ff.status == STATUS_OK)
      |-> (res_ff.block_order == req_ff))
      else $error("granted order differs from the requested order");

endmodule

// ===== rtl/buddy_page_allocator.sv =====
`timescale 1ns / 1ps
// Binary buddy page allocator. Usage:
// - req_* channel (valid/ready): op selects allocate or free; req_order is the log2 size
//   wanted on allocate, free_page the first page of the block handed back on free.
// - rsp_* channel (valid/ready): one beat per request with status (ok or out of memory),
//   block_page and block_order of the granted or merged block.
// - After reset the block sweeps its page memories, one page per cycle, over all POOL_PAGES
//   pages (1024 by default); req_ready stays low until the sweep ends. The whole pool is
//   then one free block of the largest order.
// - One request is worked on at a time. An allocate scans the free lists upward from the
//   requested order to the first non-empty one (out of memory if none), unlinks its head
//   and splits it down, pushing each upper half onto its list. A free reads the order of
//   the block and merges it with its free buddy until the buddy is busy or the largest
//   order is reached. The result beat is offered from the output register.
// - The result sits in an output register; a stalled receiver holds it there while the
//   next request is already being worked on, and the sequencer waits only if a second
//   result is ready before the first is taken.
// Depends on bpa_pkg, bpa_seq and bpa_ram.
module buddy_page_allocator #(
   parameter int MAX_ORDER  = bpa_pkg::DEF_MAX_ORDER,
   parameter int POOL_PAGES = bpa_pkg::DEF_POOL_PAGES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bpa_pkg::rsp_type rsp_data
);
   import bpa_pkg::*;

   logic    done_valid;
   logic    done_ready;
   rsp_type done_data;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   bpa_seq #(.MAX_ORDER(MAX_ORDER), .POOL_PAGES(POOL_PAGES)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .done_valid(done_valid),
      .done_ready(done_ready),
      .done_data (done_data)
   );

   // Output register: load when empty or being drained.
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_ready) begin
         rsp_valid_in = done_valid;
         if (done_valid) begin
            rsp_data_in = done_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
